@@ sv/pvlb_pkg.sv @@
// Package for the presence variance leaky-bucket core.
// Beat structs, configuration register indexes, reset values and parameter defaults.
// No dependencies.
`default_nettype none

package pvlb_pkg;

    // Parameter defaults
    localparam int WINDOW_LENGTH_DEF = 10;
    localparam int SAMPLE_WIDTH_DEF  = 10;
    localparam int COUNT_WIDTH_DEF   = 10;

    // Fixed field widths of the beats
    localparam int ENERGY_W  = 10;
    localparam int PRES_W    = 2;
    localparam int WSUM_W    = 14;
    localparam int VAR_W     = 25;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int LEVEL_W     = 10;
    localparam int LIMIT_W     = 16;
    localparam int FRAMES_W    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_FIELD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAINTAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_VAR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIDGET_VAR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_FRM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_FRM    = 3'd6;

    // Register reset values
    localparam logic                RST_NEAR_FIELD = 1'b1;
    localparam logic [LEVEL_W-1:0]  RST_TRIGGER    = 10'd400;
    localparam logic [LEVEL_W-1:0]  RST_MAINTAIN   = 10'd400;
    localparam logic [LIMIT_W-1:0]  RST_MOTION_VAR = 16'd96;
    localparam logic [LIMIT_W-1:0]  RST_FIDGET_VAR = 16'd2560;
    localparam logic [FRAMES_W-1:0] RST_ENTRY_FRM  = 10'd100;
    localparam logic [FRAMES_W-1:0] RST_EXIT_FRM   = 10'd300;

    // Input beat
    typedef struct packed {
        logic                mode;
        logic [ENERGY_W-1:0] energy_sample;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic              window_full;
        logic [PRES_W-1:0] presence_state;
        logic              state_changed;
        logic [WSUM_W-1:0] window_sum;
        logic [VAR_W-1:0]  variance_scaled;
    } t_out_beat;

endpackage

`default_nettype wire

@@ sv/pvlb_window.sv @@
// Sample ring with running sum and running sum of squares.
// Depends on pvlb_pkg for parameter defaults.
`default_nettype none

module pvlb_window import pvlb_pkg::*; #(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    localparam int AW    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1,
    localparam int FILLW = $clog2(WINDOW_LENGTH + 1),
    localparam int SUMW  = SAMPLE_WIDTH + $clog2(WINDOW_LENGTH),
    localparam int SQW   = 2 * SAMPLE_WIDTH + $clog2(WINDOW_LENGTH)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_ld,
    input  wire logic                    i_clr,
    input  wire logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                         o_full,
    output logic [SUMW-1:0]              o_sum,
    output logic [SQW-1:0]               o_sq
);

    localparam int SQ1W = 2 * SAMPLE_WIDTH;

    logic [SAMPLE_WIDTH-1:0] r_ring [WINDOW_LENGTH];
    logic [AW-1:0]           r_wpos, n_wpos;
    logic [FILLW-1:0]        r_fill, n_fill;
    logic [SUMW-1:0]         r_sum, n_sum;
    logic [SQW-1:0]          r_sq, n_sq;

    logic                    full;
    logic [SAMPLE_WIDTH-1:0] old;
    logic [SQ1W-1:0]         old_sq, new_sq;

    // Oldest sample leaves the sums only once the ring is full
    assign full   = (r_fill == FILLW'(WINDOW_LENGTH));
    assign old    = full ? r_ring[r_wpos] : '0;
    assign old_sq = SQ1W'(old) * SQ1W'(old);
    assign new_sq = SQ1W'(i_sample) * SQ1W'(i_sample);

    always_comb begin
        n_sum  = r_sum - SUMW'(old) + SUMW'(i_sample);
        n_sq   = r_sq - SQW'(old_sq) + SQW'(new_sq);
        n_wpos = (r_wpos == AW'(WINDOW_LENGTH - 1)) ? '0 : r_wpos + 1'b1;
        n_fill = full ? r_fill : r_fill + 1'b1;
    end

    // Ring storage, no reset: an entry is read only after it was written
    always_ff @(posedge i_clk) begin
        if (i_ld && !i_clr) begin
            r_ring[r_wpos] <= i_sample;
        end
    end

    // Position, fill and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
        end else if (i_ld) begin
            if (i_clr) begin
                r_wpos <= '0;
                r_fill <= '0;
                r_sum  <= '0;
                r_sq   <= '0;
            end else begin
                r_wpos <= n_wpos;
                r_fill <= n_fill;
                r_sum  <= n_sum;
                r_sq   <= n_sq;
            end
        end
    end

    // The sums describe the beat last loaded, which is what the next stage takes
    assign o_full = full;
    assign o_sum  = r_sum;
    assign o_sq   = r_sq;

endmodule

`default_nettype wire

@@ sv/presence_variance_leaky_bucket_fsm_core.sv @@
// Top level of the presence variance leaky-bucket core.
// The input beat is registered, then passes the window, variance and judge stages to the result.
// Throughput: one beat per cycle; the running-sum update and the presence state
// machine each close a single-cycle loop, and a stalled output blocks only once
// the three pipeline registers ahead of it are full.
// Reset: synchronous, active low; clears pipeline valids, sums, counters, state,
// and loads register defaults. The sample ring is not cleared.
`default_nettype none

module presence_variance_leaky_bucket_fsm_core import pvlb_pkg::*; #(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_beat              i_in_data,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_beat                  o_out_data,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUMW = SAMPLE_WIDTH + $clog2(WINDOW_LENGTH);
    localparam int SQW  = 2 * SAMPLE_WIDTH + $clog2(WINDOW_LENGTH);
    localparam int VW   = 2 * SAMPLE_WIDTH + 2 * $clog2(WINDOW_LENGTH);
    localparam int NN   = WINDOW_LENGTH * WINDOW_LENGTH;
    localparam int CMPW = (COUNT_WIDTH > FRAMES_W) ? COUNT_WIDTH : FRAMES_W;

    typedef enum logic [PRES_W-1:0] {
        ST_AWAY   = 2'd0,
        ST_NORMAL = 2'd1,
        ST_FIDGET = 2'd2
    } t_pres_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                r_near_field;
    logic [LEVEL_W-1:0]  r_trigger, r_maintain;
    logic [LIMIT_W-1:0]  r_motion_var, r_fidget_var;
    logic [FRAMES_W-1:0] r_entry_frm, r_exit_frm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_field <= RST_NEAR_FIELD;
            r_trigger    <= RST_TRIGGER;
            r_maintain   <= RST_MAINTAIN;
            r_motion_var <= RST_MOTION_VAR;
            r_fidget_var <= RST_FIDGET_VAR;
            r_entry_frm  <= RST_ENTRY_FRM;
            r_exit_frm   <= RST_EXIT_FRM;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NEAR_FIELD: r_near_field <= i_cfg_data[0];
                CFG_TRIGGER:    r_trigger    <= i_cfg_data[LEVEL_W-1:0];
                CFG_MAINTAIN:   r_maintain   <= i_cfg_data[LEVEL_W-1:0];
                CFG_MOTION_VAR: r_motion_var <= i_cfg_data[LIMIT_W-1:0];
                CFG_FIDGET_VAR: r_fidget_var <= i_cfg_data[LIMIT_W-1:0];
                CFG_ENTRY_FRM:  r_entry_frm  <= i_cfg_data[FRAMES_W-1:0];
                CFG_EXIT_FRM:   r_exit_frm   <= i_cfg_data[FRAMES_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage loads when empty or moving on
    // ------------------------------------------------------------------
    logic r_v0, r_va, r_vb;
    logic rdy_o, rdy_b, rdy_a;
    logic ld_a, ld_b, ld_c;

    assign rdy_o      = !o_out_valid || i_out_ready;
    assign ld_c       = r_vb && rdy_o;
    assign rdy_b      = !r_vb || rdy_o;
    assign ld_b       = r_va && rdy_b;
    assign rdy_a      = !r_va || rdy_b;
    assign ld_a       = r_v0 && rdy_a;
    assign o_in_ready = !r_v0 || rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (o_in_ready) r_v0 <= i_in_valid;
            if (rdy_a)      r_va <= r_v0;
            if (rdy_b)      r_vb <= r_va;
        end
    end

    // Input register
    t_in_beat r_in;

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: ring and running sums
    // ------------------------------------------------------------------
    logic            a_full;
    logic [SUMW-1:0] a_sum;
    logic [SQW-1:0]  a_sq;
    logic            r_a_clr;

    pvlb_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ld     (ld_a),
        .i_clr    (r_in.mode),
        .i_sample (SAMPLE_WIDTH'(r_in.energy_sample)),
        .o_full   (a_full),
        .o_sum    (a_sum),
        .o_sq     (a_sq)
    );

    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_a_clr <= r_in.mode;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: scaled variance V = N*Q - S*S
    // ------------------------------------------------------------------
    logic [VW-1:0]   n_b_v;
    logic [VW-1:0]   r_b_v;
    logic [SUMW-1:0] r_b_s;
    logic            r_b_full, r_b_clr;

    assign n_b_v = VW'(a_sq) * VW'(WINDOW_LENGTH) - VW'(a_sum) * VW'(a_sum);

    always_ff @(posedge i_clk) begin
        if (ld_b) begin
            r_b_v    <= n_b_v;
            r_b_s    <= a_sum;
            r_b_full <= a_full && !r_a_clr;
            r_b_clr  <= r_a_clr;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: judgement and presence state machine
    // ------------------------------------------------------------------
    logic [VW-1:0] th_motion, th_fidget, th_trig, th_maint, s_ext;
    logic          cond_in, cond_out;

    // Thresholds scaled by N and N*N
    assign th_motion = VW'(r_motion_var) * VW'(NN);
    assign th_fidget = VW'(r_fidget_var) * VW'(NN);
    assign th_trig   = VW'(r_trigger) * VW'(WINDOW_LENGTH);
    assign th_maint  = VW'(r_maintain) * VW'(WINDOW_LENGTH);
    assign s_ext     = VW'(r_b_s);

    always_comb begin
        if (r_near_field) begin
            cond_in  = r_b_v > th_motion;
            cond_out = r_b_v < th_motion;
        end else begin
            cond_in  = s_ext > th_trig;
            cond_out = (s_ext < th_maint) && (r_b_v < th_motion);
        end
    end

    t_pres_state            r_pres, n_pres, r_prev, n_prev;
    logic [COUNT_WIDTH-1:0] r_credit, n_credit, r_exit, n_exit;
    logic [COUNT_WIDTH-1:0] credit_step, exit_step;
    t_out_beat              r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    always_comb begin
        n_pres      = r_pres;
        n_prev      = r_prev;
        n_credit    = r_credit;
        n_exit      = r_exit;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        credit_step = r_credit;
        exit_step   = r_exit;

        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (ld_c) begin
            n_out_valid = 1'b1;
            if (r_b_clr) begin
                // clear beat: everything back to away, result all zero
                n_pres   = ST_AWAY;
                n_prev   = ST_AWAY;
                n_credit = '0;
                n_exit   = '0;
                n_out    = '0;
            end else if (!r_b_full) begin
                // window still filling: report the state as it stands
                n_out                = '0;
                n_out.presence_state = r_pres;
            end else begin
                if (r_pres == ST_AWAY) begin
                    // leaky-bucket entry credit, saturating both ways
                    if (cond_in) begin
                        credit_step = (r_credit != '1) ? r_credit + 1'b1 : r_credit;
                    end else begin
                        credit_step = (r_credit != '0) ? r_credit - 1'b1 : r_credit;
                    end
                    if (CMPW'(credit_step) >= CMPW'(r_entry_frm)) begin
                        n_pres   = ST_NORMAL;
                        n_credit = '0;
                    end else begin
                        n_credit = credit_step;
                    end
                end else begin
                    // exit count restarts on any break in the quiet run
                    if (cond_out) begin
                        exit_step = (r_exit != '1) ? r_exit + 1'b1 : r_exit;
                    end else begin
                        exit_step = '0;
                    end
                    if (CMPW'(exit_step) >= CMPW'(r_exit_frm)) begin
                        n_pres = ST_AWAY;
                        n_exit = '0;
                    end else begin
                        n_exit = exit_step;
                        n_pres = (r_b_v > th_fidget) ? ST_FIDGET : ST_NORMAL;
                    end
                end
                n_prev                = n_pres;
                n_out.window_full     = 1'b1;
                n_out.presence_state  = n_pres;
                n_out.state_changed   = (n_pres != r_prev);
                n_out.window_sum      = WSUM_W'(r_b_s);
                n_out.variance_scaled = VAR_W'(r_b_v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pres      <= ST_AWAY;
            r_prev      <= ST_AWAY;
            r_credit    <= '0;
            r_exit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pres      <= n_pres;
            r_prev      <= n_prev;
            r_credit    <= n_credit;
            r_exit      <= n_exit;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // Entry credit builds only while away
    a_credit_away: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pres != ST_AWAY) |-> (r_credit == '0))
        else $error("entry credit nonzero outside away");

    // Exit count runs only while present
    a_exit_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pres == ST_AWAY) |-> (r_exit == '0))
        else $error("exit count nonzero while away");

    // Presence moves only on a judged or clear beat
    a_pres_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!ld_c || (!r_b_clr && !r_b_full)) |=> $stable(r_pres))
        else $error("presence changed without a judgement");

    // An unjudged result carries no statistics and no change flag
    a_unjudged_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.window_full) |->
        (!o_out_data.state_changed && o_out_data.window_sum == '0 &&
         o_out_data.variance_scaled == '0))
        else $error("unjudged result carries statistics");
`endif

endmodule

`default_nettype wire
